>>> src/bscd_pkg.sv
// Shared types, constants and the CRC-8 step function of the byte-stuffed deframer.
`default_nettype none

package bscd_pkg;

	localparam logic [7:0] DELIM_RESET  = 8'hD5;
	localparam logic [7:0] ESCAPE_RESET = 8'h5C;
	localparam logic [7:0] POLY_RESET   = 8'h07;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELIM  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLY   = 2'd2;

	localparam logic [1:0] STATUS_GOOD = 2'd0;
	localparam logic [1:0] STATUS_CRC  = 2'd1;
	localparam logic [1:0] STATUS_LONG = 2'd2;

	typedef enum logic {
		ST_RECV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       store;
		logic       esc_set;
		logic       esc_clr;
		logic       close;
		logic       start_emit;
		logic       status_item;
		logic [1:0] status_code;
		logic       emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic esc_pend;
		logic is_esc;
		logic is_delim;
		logic empty;
		logic ovf;
		logic good;
		logic out_free;
		logic emit_done;
	} dp_sts_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/bscd_if.sv
// Valid/ready channel interfaces for received link bytes and deframed result beats.
`default_nettype none

interface bscd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface bscd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	logic [1:0] status;

	modport source(output valid, output data_byte, output last, output status, input ready);
	modport sink(input valid, input data_byte, input last, input status, output ready);
endinterface

`default_nettype wire

>>> src/bscd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bscd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/bscd_ctrl.sv
// Controller state machine: decodes each link beat and sequences frame readout.
`default_nettype none

module bscd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bscd_pkg::dp_sts_t  sts,
	output bscd_pkg::ctrl_cmd_t     cmd
);
	import bscd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RECV: begin
				if (cmd.start_emit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.emit_done) begin
					state_d = ST_RECV;
				end
			end
			default: state_d = ST_RECV;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_RECV: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (sts.esc_pend) begin
						cmd.esc_clr = 1'b1;
						cmd.store   = 1'b1;
					end else if (sts.is_esc) begin
						cmd.esc_set = 1'b1;
					end else if (sts.is_delim) begin
						if (!sts.empty) begin
							cmd.close = 1'b1;
							if (sts.ovf) begin
								cmd.status_item = 1'b1;
								cmd.status_code = STATUS_LONG;
							end else if (!sts.good) begin
								cmd.status_item = 1'b1;
								cmd.status_code = STATUS_CRC;
							end else begin
								cmd.start_emit = 1'b1;
							end
						end
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> src/bscd_dp.sv
// Datapath: config registers, frame buffer, running CRC, readout pipeline and output register.
`default_nettype none

module bscd_dp #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [bscd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [7:0]                           cfg_wdata,
	input  wire logic [7:0]                           rx_byte,
	input  wire bscd_pkg::ctrl_cmd_t                  cmd,
	output bscd_pkg::dp_sts_t                         sts,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [7:0]                                out_data_byte,
	output logic                                      out_last,
	output logic [1:0]                                out_status
);
	import bscd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FRAME + 1);
	localparam int unsigned AW = $clog2(MAX_FRAME);

	logic [7:0]    delim_q;
	logic [7:0]    escape_q;
	logic [7:0]    poly_q;
	logic [CW-1:0] fill_q;
	logic [7:0]    crc_q;
	logic          esc_q;
	logic          ovf_q;
	logic [AW-1:0] len_q;
	logic [AW-1:0] idx_q;
	logic          pend_q;
	logic          pend_last_q;
	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;
	logic [1:0]    out_status_q;

	logic          full;
	logic          wr_en;
	logic          out_load;
	logic          rd_en;
	logic [7:0]    rd_data;

	// Hold register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q  <= DELIM_RESET;
			escape_q <= ESCAPE_RESET;
			poly_q   <= POLY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DELIM:  delim_q  <= cfg_wdata;
				CFG_ESCAPE: escape_q <= cfg_wdata;
				CFG_POLY:   poly_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign full     = (fill_q == CW'(MAX_FRAME));
	assign wr_en    = cmd.store && !full;
	assign out_load = pend_q && (!out_valid_q || out_ready);
	assign rd_en    = cmd.emit && (idx_q != len_q) && (!pend_q || out_load);

	bscd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_FRAME)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(fill_q[AW-1:0]),
		.wr_data(rx_byte),
		.rd_en  (rd_en),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crc_q  <= '0;
			esc_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.esc_set) begin
				esc_q <= 1'b1;
			end else if (cmd.esc_clr) begin
				esc_q <= 1'b0;
			end
			if (cmd.close) begin
				fill_q <= '0;
				crc_q  <= '0;
				ovf_q  <= 1'b0;
			end else if (cmd.store) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= CW'(fill_q + CW'(1));
					crc_q  <= crc8_update(crc_q, rx_byte, poly_q);
				end
			end
		end
	end

	// Advance the readout: RAM read register feeds the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (cmd.start_emit) begin
				len_q <= AW'(CW'(fill_q - CW'(1)));
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= AW'(idx_q + AW'(1));
			end
			if (rd_en) begin
				pend_q      <= 1'b1;
				pend_last_q <= (AW'(idx_q + AW'(1)) == len_q);
			end else if (out_load) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || cmd.status_item) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= rd_data;
			out_last_q   <= pend_last_q;
			out_status_q <= STATUS_GOOD;
		end else if (cmd.status_item) begin
			out_data_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.status_code;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data_byte = out_data_q;
	assign out_last      = out_last_q;
	assign out_status    = out_status_q;

	always_comb begin
		sts.esc_pend  = esc_q;
		sts.is_esc    = (rx_byte == escape_q);
		sts.is_delim  = (rx_byte == delim_q);
		sts.empty     = (fill_q == '0) && !ovf_q;
		sts.ovf       = ovf_q;
		sts.good      = (fill_q >= CW'(2)) && (crc_q == '0);
		sts.out_free  = !out_valid_q || out_ready;
		sts.emit_done = out_load && pend_last_q;
	end

endmodule

`default_nettype wire

>>> src/byte_stuffed_crc8_deframer_unit.sv
// Byte-stuffed CRC-8 deframer: receives link bytes, checks frames and delivers payload beats.
// While receiving, the block takes one link byte per cycle whenever the output register is free
// or being drained. A closing delimiter of a good frame of N stored bytes stops input while the
// N-1 payload bytes are read back from the frame buffer's registered read port, one beat per
// cycle unless held by output back-pressure. A bad or overlong frame yields a single status
// beat. The frame buffer needs no clearing pass after reset.
`default_nettype none

module byte_stuffed_crc8_deframer_unit #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bscd_in_if.sink                               link,
	bscd_out_if.source                            frame,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bscd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                       cfg_wdata
);
	import bscd_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;
	logic      in_ready;

	bscd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(link.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bscd_dp #(
		.MAX_FRAME(MAX_FRAME)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.rx_byte      (link.rx_byte),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (frame.valid),
		.out_ready    (frame.ready),
		.out_data_byte(frame.data_byte),
		.out_last     (frame.last),
		.out_status   (frame.status)
	);

	assign link.ready = in_ready;

	a_emit_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_emit |=> !link.ready)
		else $error("input accepted during frame readout");

	a_done_ends_emit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.emit_done |=> !cmd.emit)
		else $error("readout continues after final beat");

	a_store_not_close: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !cmd.close && !cmd.status_item)
		else $error("store and close in one beat");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && (frame.status != STATUS_GOOD) |-> frame.last && (frame.data_byte == '0))
		else $error("status beat without last mark");

endmodule

`default_nettype wire
